### rtl/core/text_mode_terminal_writer_defines.svh
// Assertion helpers for the terminal writer.
`ifndef TEXT_MODE_TERMINAL_WRITER_DEFINES_SVH
`define TEXT_MODE_TERMINAL_WRITER_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked at every edge outside reset.
`define TMTW_ASSERT(lbl, clk_i, rstn_i, prop_i) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop_i)) \
		else $error("tmtw assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TMTW_ASSERT_NEXT(lbl, clk_i, rstn_i, ante_i, cons_i) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante_i) |=> (cons_i)) \
		else $error("tmtw assertion failed");

`else

`define TMTW_ASSERT(lbl, clk_i, rstn_i, prop_i)
`define TMTW_ASSERT_NEXT(lbl, clk_i, rstn_i, ante_i, cons_i)

`endif

`endif

### rtl/core/tmtw_pkg.sv
`default_nettype none

package tmtw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int CELL_W = 16;

	localparam logic [7:0] ATTR_RESET = 8'h07;
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_SPACE   = 8'd32;

	typedef enum logic [1:0] {
		ACT_PUT   = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_READ  = 2'd2
	} action_t;

endpackage

`default_nettype wire

### rtl/core/tmtw_item_if.sv
`default_nettype none

// Input channel: one terminal action per transfer.
interface tmtw_item_if;
	logic              valid;
	logic              ready;
	tmtw_pkg::action_t action;
	logic [7:0]        char_code;
	logic [4:0]        read_row;
	logic [6:0]        read_column;

	modport source (output valid, action, char_code, read_row, read_column, input ready);
	modport sink (input valid, action, char_code, read_row, read_column, output ready);
endinterface

`default_nettype wire

### rtl/core/tmtw_result_if.sv
`default_nettype none

// Result channel: cell read back plus cursor after the action.
interface tmtw_result_if;
	logic                        valid;
	logic                        ready;
	logic [tmtw_pkg::CELL_W-1:0] cell_value;
	logic [4:0]                  cursor_row_now;
	logic [6:0]                  cursor_column_now;

	modport source (output valid, cell_value, cursor_row_now, cursor_column_now, input ready);
	modport sink (input valid, cell_value, cursor_row_now, cursor_column_now, output ready);
endinterface

`default_nettype wire

### rtl/core/text_mode_terminal_writer.sv
// Text terminal writer: character-cell screen in one RAM plus a cursor.
// One item at a time; the next is taken once the result is registered.
// Cost is set by the single write port: scroll and clear touch every cell, one a cycle.
// Reset (arst_n low, async): cursor home, attribute 7, then a blanking pass over every cell.
`default_nettype none

`include "text_mode_terminal_writer_defines.svh"

module text_mode_terminal_writer #(
	parameter int COLUMNS = tmtw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tmtw_pkg::ROWS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	tmtw_item_if.sink       item_in,
	tmtw_result_if.source   result_out,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS + 1);
	// cells moved by a scroll: everything below the top row
	localparam int MOVE  = (ROWS - 1) * COLUMNS;

	localparam logic [AW-1:0] MOVE_A   = AW'(MOVE);
	localparam logic [AW-1:0] LAST_A   = AW'(CELLS - 1);
	localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
	localparam logic [CW-1:0] COL_END  = CW'(COLUMNS);

	// one-hot sequencer
	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_PUT_WR  = 7'b0000010,
		ST_RD_ADDR = 7'b0000100,
		ST_RD_DATA = 7'b0001000,
		ST_SCROLL  = 7'b0010000,
		ST_FILL    = 7'b0100000,
		ST_DONE    = 7'b1000000
	} state_t;

	state_t state_q;

	logic [7:0]    attr_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [AW-1:0] cnt_q;
	logic          init_q;     // blanking pass after reset, no result
	logic          mv_v_s1;    // scroll: read issued last cycle
	logic [AW-1:0] mv_a_s1;    // scroll: destination of that read

	// item payload
	logic [7:0] char_q;
	logic [4:0] rrow_q;
	logic [6:0] rcol_q;
	logic [tmtw_pkg::CELL_W-1:0] cell_q;

	// output register
	logic                        out_valid_q;
	logic [tmtw_pkg::CELL_W-1:0] out_cell_q;
	logic [4:0]                  out_row_q;
	logic [6:0]                  out_col_q;

	logic accept;
	logic out_load;

	// shared address unit
	logic [RW-1:0] ua;
	logic [AW-1:0] ub;
	logic [AW-1:0] uaddr;

	// RAM side
	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [tmtw_pkg::CELL_W-1:0] ram_wdata;
	logic [tmtw_pkg::CELL_W-1:0] ram_rdata;
	logic [7:0]                  blank_attr;

	// put: pending wrap and bottom clamp
	logic          wrap;
	logic [RW:0]   row_inc;
	logic [RW-1:0] put_row;
	logic          rd_in_range;

	assign item_in.ready = (state_q == ST_IDLE);
	assign accept        = item_in.valid && item_in.ready;
	assign out_load      = (state_q == ST_DONE) && (!out_valid_q || result_out.ready);

	assign result_out.valid             = out_valid_q;
	assign result_out.cell_value        = out_cell_q;
	assign result_out.cursor_row_now    = out_row_q;
	assign result_out.cursor_column_now = out_col_q;

	always_comb begin
		wrap    = (col_q >= COL_END);
		row_inc = {1'b0, row_q} + (RW+1)'(1);
		if (!wrap) begin
			put_row = row_q;
		end else if (row_inc >= (RW+1)'(ROWS)) begin
			put_row = ROW_LAST;
		end else begin
			put_row = row_inc[RW-1:0];
		end
		rd_in_range = (int'(rrow_q) < ROWS) && (int'(rcol_q) < COLUMNS);
	end

	// address unit operands per step
	always_comb begin
		case (state_q)
			ST_PUT_WR: begin
				ua = row_q;
				ub = AW'(col_q);
			end
			ST_RD_ADDR: begin
				ua = RW'(rrow_q);
				ub = AW'(rcol_q);
			end
			ST_SCROLL: begin
				ua = RW'(1);       // source is one row below
				ub = cnt_q;
			end
			default: begin
				ua = '0;
				ub = cnt_q;
			end
		endcase
	end

	tmtw_addr_unit #(
		.COLUMNS(COLUMNS),
		.RW     (RW),
		.AW     (AW)
	) u_addr (
		.mul_a(ua),
		.add_b(ub),
		.addr (uaddr)
	);

	// reset pass blanks with the reset attribute, clear uses the live one
	assign blank_attr = init_q ? tmtw_pkg::ATTR_RESET : attr_q;

	always_comb begin
		case (state_q)
			ST_PUT_WR: begin
				ram_we    = 1'b1;
				ram_waddr = uaddr;
				ram_wdata = {attr_q, char_q};
			end
			ST_SCROLL: begin
				ram_we    = mv_v_s1;
				ram_waddr = mv_a_s1;
				ram_wdata = ram_rdata;
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = {blank_attr, tmtw_pkg::CH_SPACE};
			end
			default: begin
				ram_we    = 1'b0;
				ram_waddr = cnt_q;
				ram_wdata = {blank_attr, tmtw_pkg::CH_SPACE};
			end
		endcase
	end

	tmtw_screen_ram #(
		.DEPTH(CELLS),
		.AW   (AW)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr  (uaddr),
		.rdata_q(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tmtw_pkg::ATTR_RESET;
		end else if (cfg_wr_en) begin
			attr_q <= cfg_wr_data;
		end
	end

	// sequencer, cursor and scroll pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			row_q   <= '0;
			col_q   <= '0;
			cnt_q   <= '0;
			init_q  <= 1'b1;
			mv_v_s1 <= 1'b0;
		end else begin
			mv_v_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item_in.action)
							tmtw_pkg::ACT_PUT: begin
								if (item_in.char_code == tmtw_pkg::CH_NEWLINE) begin
									col_q <= '0;
									if (row_q == ROW_LAST) begin
										cnt_q   <= '0;
										state_q <= ST_SCROLL;
									end else begin
										row_q   <= row_q + RW'(1);
										state_q <= ST_DONE;
									end
								end else begin
									row_q   <= put_row;
									col_q   <= wrap ? '0 : col_q;
									state_q <= ST_PUT_WR;
								end
							end
							tmtw_pkg::ACT_CLEAR: begin
								row_q   <= '0;
								col_q   <= '0;
								cnt_q   <= '0;
								state_q <= ST_FILL;
							end
							tmtw_pkg::ACT_READ: begin
								state_q <= ST_RD_ADDR;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_PUT_WR: begin
					col_q   <= col_q + CW'(1);
					state_q <= ST_DONE;
				end
				ST_RD_ADDR: begin
					state_q <= ST_RD_DATA;
				end
				ST_RD_DATA: begin
					state_q <= ST_DONE;
				end
				ST_SCROLL: begin
					// read cnt+COLUMNS now, write it back to cnt next cycle
					if (cnt_q != MOVE_A) begin
						mv_v_s1 <= 1'b1;
						cnt_q   <= cnt_q + AW'(1);
					end else begin
						state_q <= ST_FILL;    // bottom row blanked from MOVE on
					end
				end
				ST_FILL: begin
					if (cnt_q == LAST_A) begin
						init_q  <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_DONE;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mv_a_s1 <= cnt_q;
		if (accept) begin
			char_q <= item_in.char_code;
			rrow_q <= item_in.read_row;
			rcol_q <= item_in.read_column;
			cell_q <= '0;
		end else if (state_q == ST_RD_DATA) begin
			cell_q <= rd_in_range ? ram_rdata : '0;
		end
	end

	// output register: frees the sequencer while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_cell_q <= cell_q;
			out_row_q  <= 5'(row_q);
			out_col_q  <= 7'(col_q);
		end
	end

	`TMTW_ASSERT(a_col_range, clk, arst_n, col_q <= COL_END)
	`TMTW_ASSERT(a_row_range, clk, arst_n, row_q <= ROW_LAST)
	`TMTW_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, state_q != ST_IDLE)
	`TMTW_ASSERT(a_we_states, clk, arst_n, !ram_we || |(state_q & (ST_PUT_WR | ST_SCROLL | ST_FILL)))

endmodule

`default_nettype wire

### rtl/core/tmtw_screen_ram.sv
`default_nettype none

// Screen store: one write port, one registered read port.
module tmtw_screen_ram #(
	parameter int DEPTH = tmtw_pkg::ROWS_DEF * tmtw_pkg::COLUMNS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               waddr,
	input  wire logic [tmtw_pkg::CELL_W-1:0] wdata,
	input  wire logic [AW-1:0]               raddr,
	output logic      [tmtw_pkg::CELL_W-1:0] rdata_q
);

	logic [tmtw_pkg::CELL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

endmodule

`default_nettype wire

### rtl/core/tmtw_addr_unit.sv
`default_nettype none

// Shared address unit: addr = mul_a * COLUMNS + add_b.
// Serves cursor writes, reads and the scroll source offset.
module tmtw_addr_unit #(
	parameter int COLUMNS = tmtw_pkg::COLUMNS_DEF,
	parameter int RW      = 5,
	parameter int AW      = 11
) (
	input  wire logic [RW-1:0] mul_a,
	input  wire logic [AW-1:0] add_b,
	output logic      [AW-1:0] addr
);

	localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);

	logic [AW-1:0] prod;

	always_comb begin
		prod = AW'(mul_a) * COLS_A;
		addr = prod + add_b;
	end

endmodule

`default_nettype wire

### sim/testbench.sv
`default_nettype none

module testbench;

	// Screen geometry; the DUT runs with the same values.
	localparam int COLS  = tmtw_pkg::COLUMNS_DEF;
	localparam int ROWS  = tmtw_pkg::ROWS_DEF;
	localparam int CELLS = COLS * ROWS;

	// Action 3 has no enum member; it must be a no-op in the DUT.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// Receiver hold-off used to back the block up.
	localparam int HOLD_CYCLES = 400;
	// Cycles with no transfer on either channel before we give up. Covers a
	// full-screen scroll or clear plus the hold-off, many times over.
	localparam int STALL_LIMIT = 20000;
	// Slack after the last result, and before a config write.
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [tmtw_pkg::CELL_W-1:0] cell_word;
		logic [4:0]                  row;
		logic [6:0]                  column;
	} screen_report_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [7:0] cfg_wr_data;

	tmtw_item_if   item_bus ();
	tmtw_result_if result_bus ();

	text_mode_terminal_writer #(
		.COLUMNS(COLS),
		.ROWS(ROWS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_in(item_bus),
		.result_out(result_bus),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// ------------------------------------------------------------------
	// Shadow of the terminal: screen, cursor and attribute register.
	// ------------------------------------------------------------------
	logic [tmtw_pkg::CELL_W-1:0] shadow_screen [CELLS];
	int                          shadow_row;
	int                          shadow_column;
	logic [7:0]                  shadow_attr;

	// Reports (cell + cursor) still owed by the DUT, oldest first.
	screen_report_t screen_reports_due [$];
	screen_report_t oldest_report;

	int mismatch_count;
	int quiet_cycles;

	// Idle rates in percent, and the receiver hold-off handshake.
	int sender_idle_pct;
	int receiver_idle_pct;
	bit hold_request;
	int hold_left;

	function automatic void blank_cells(int first, int count);
		for (int i = first; i < first + count; i++)
			shadow_screen[i] = {shadow_attr, tmtw_pkg::CH_SPACE};
	endfunction

	// Advance the shadow by one accepted action and queue the report it owes.
	function automatic void predict_terminal_action(tmtw_pkg::action_t act, logic [7:0] code,
		logic [4:0] rd_row, logic [6:0] rd_col);
		screen_report_t rep;
		rep.cell_word = '0;
		case (act)
			tmtw_pkg::ACT_PUT: begin
				if (code == tmtw_pkg::CH_NEWLINE) begin
					shadow_column = 0;
					shadow_row++;
					if (shadow_row >= ROWS) begin
						// newline past bottom: scroll up, blank the last row
						shadow_row = ROWS - 1;
						for (int i = 0; i < (ROWS - 1) * COLS; i++)
							shadow_screen[i] = shadow_screen[i + COLS];
						blank_cells((ROWS - 1) * COLS, COLS);
					end
				end else begin
					// pending wrap resolves before the write
					if (shadow_column >= COLS) begin
						shadow_column = 0;
						shadow_row++;
					end
					// below the bottom: clamp, no scroll
					if (shadow_row >= ROWS)
						shadow_row = ROWS - 1;
					shadow_screen[shadow_row * COLS + shadow_column] = {shadow_attr, code};
					shadow_column++;
				end
			end
			tmtw_pkg::ACT_CLEAR: begin
				blank_cells(0, CELLS);
				shadow_row = 0;
				shadow_column = 0;
			end
			tmtw_pkg::ACT_READ: begin
				if (rd_row < ROWS && rd_col < COLS)
					rep.cell_word = shadow_screen[rd_row * COLS + rd_col];
			end
			default: ;
		endcase
		rep.row = shadow_row[4:0];
		rep.column = shadow_column[6:0];
		screen_reports_due.push_back(rep);
	endfunction

	// ------------------------------------------------------------------
	// Clock, receiver, checker, watchdog
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver: ready changes on the falling edge. A hold-off request loads hold_left
	// with HOLD_CYCLES and pins ready low here while that count runs down.
	initial begin
		result_bus.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready = 1'b0;
			end else begin
				result_bus.ready = ($urandom_range(99) >= receiver_idle_pct);
			end
		end
	end

	// Every result transfer is matched against the oldest report owed.
	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (screen_reports_due.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result: cell %h row %0d column %0d", $time,
					result_bus.cell_value, result_bus.cursor_row_now,
					result_bus.cursor_column_now);
			end else begin
				oldest_report = screen_reports_due.pop_front();
				if (result_bus.cell_value !== oldest_report.cell_word) begin
					mismatch_count++;
					$display("%0t: cell_value expected %h got %h", $time,
						oldest_report.cell_word, result_bus.cell_value);
				end
				if (result_bus.cursor_row_now !== oldest_report.row) begin
					mismatch_count++;
					$display("%0t: cursor_row_now expected %0d got %0d", $time,
						oldest_report.row, result_bus.cursor_row_now);
				end
				if (result_bus.cursor_column_now !== oldest_report.column) begin
					mismatch_count++;
					$display("%0t: cursor_column_now expected %0d got %0d", $time,
						oldest_report.column, result_bus.cursor_column_now);
				end
			end
		end
	end

	// Watchdog: any transfer on either side resets the count.
	always @(posedge clk) begin
		if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("testbench NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sender side. All tasks start and end on a falling edge.
	// ------------------------------------------------------------------

	// Offer one action, wait for the transfer, then predict it.
	task automatic send_item(tmtw_pkg::action_t act, logic [7:0] code, logic [4:0] rd_row,
		logic [6:0] rd_col);
		while ($urandom_range(99) < sender_idle_pct)
			@(negedge clk);
		item_bus.valid = 1'b1;
		item_bus.action = act;
		item_bus.char_code = code;
		item_bus.read_row = rd_row;
		item_bus.read_column = rd_col;
		do @(posedge clk); while (!item_bus.ready);
		predict_terminal_action(act, code, rd_row, rd_col);
		@(negedge clk);
		// next send_item may raise it again in this same step (blocking)
		item_bus.valid = 1'b0;
	endtask

	// Any byte but newline, so a line stays one line.
	function automatic logic [7:0] random_glyph();
		logic [7:0] g;
		g = 8'($urandom_range(255));
		if (g == tmtw_pkg::CH_NEWLINE)
			g = ~g;
		return g;
	endfunction

	task automatic put_glyph(logic [7:0] code);
		send_item(tmtw_pkg::ACT_PUT, code, 5'($urandom_range(31)), 7'($urandom_range(127)));
	endtask

	task automatic put_newline();
		send_item(tmtw_pkg::ACT_PUT, tmtw_pkg::CH_NEWLINE, 5'($urandom_range(31)),
			7'($urandom_range(127)));
	endtask

	task automatic read_cell(logic [4:0] rd_row, logic [6:0] rd_col);
		send_item(tmtw_pkg::ACT_READ, 8'($urandom_range(255)), rd_row, rd_col);
	endtask

	task automatic clear_screen();
		send_item(tmtw_pkg::ACT_CLEAR, 8'($urandom_range(255)), 5'($urandom_range(31)),
			7'($urandom_range(127)));
	endtask

	// Unused action: just reports the cursor.
	task automatic peek_cursor();
		send_item(tmtw_pkg::action_t'(ACT_UNUSED), 8'($urandom_range(255)),
			5'($urandom_range(31)), 7'($urandom_range(127)));
	endtask

	task automatic wait_drained();
		while (screen_reports_due.size() != 0)
			@(negedge clk);
	endtask

	// Attribute register: written only with nothing in flight.
	task automatic set_attribute(logic [7:0] attr);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = attr;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		cfg_wr_data = 8'($urandom_range(255));
		shadow_attr = attr;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Screen after reset: blanks in attribute 7, edges and out-of-range reads.
	task automatic test_reset_screen();
		read_cell(5'd0, 7'd0);
		read_cell(5'(ROWS - 1), 7'(COLS - 1));
		read_cell(5'(ROWS), 7'd0);
		read_cell(5'(ROWS - 1), 7'(COLS));
		read_cell(5'd31, 7'd127);
		peek_cursor();
	endtask

	// Every action at least once, the puts including extreme character codes.
	task automatic test_put_basics();
		put_glyph(8'h00);
		put_glyph(8'hFF);
		put_newline();
		put_glyph(8'hA5);
		read_cell(5'd0, 7'd0);
		read_cell(5'd0, 7'd1);
		read_cell(5'd1, 7'd0);
		read_cell(5'd0, 7'd2);
		clear_screen();
		read_cell(5'd0, 7'd0);
		read_cell(5'd1, 7'd0);
		peek_cursor();
	endtask

	// Lines around the screen width: pending wrap, put at a pending wrap,
	// newline straight after a pending wrap.
	task automatic test_line_wrap();
		int len;
		clear_screen();
		for (int line = 0; line < 4; line++) begin
			len = (line == 1) ? COLS : $urandom_range(COLS - 2, COLS + 2);
			for (int i = 0; i < len; i++)
				put_glyph(random_glyph());
			peek_cursor();
			if (line == 1)
				put_newline();
			read_cell(5'(shadow_row), 7'(COLS - 1));
			read_cell(5'(shadow_row), 7'd0);
			read_cell(5'($urandom_range(ROWS - 1)), 7'($urandom_range(COLS - 1)));
		end
	endtask

	// Short lines until the cursor passes the bottom several times.
	task automatic test_scroll_bottom();
		clear_screen();
		for (int line = 0; line < ROWS + 5; line++) begin
			for (int i = $urandom_range(6); i > 0; i--)
				put_glyph(random_glyph());
			put_newline();
			read_cell(5'(ROWS - 1), 7'($urandom_range(7)));
			read_cell(5'(ROWS - 2), 7'($urandom_range(7)));
			if (line % 5 == 0)
				read_cell(5'd0, 7'($urandom_range(7)));
		end
	endtask

	// At the last row, run past the width: the row clamps and is overwritten.
	task automatic test_bottom_clamp();
		while (shadow_row != ROWS - 1)
			put_newline();
		for (int i = 0; i < COLS + 3; i++)
			put_glyph(random_glyph());
		peek_cursor();
		read_cell(5'(ROWS - 1), 7'd0);
		read_cell(5'(ROWS - 1), 7'd2);
		read_cell(5'(ROWS - 1), 7'(COLS - 1));
		read_cell(5'(ROWS - 2), 7'd0);
		put_newline();
		read_cell(5'(ROWS - 2), 7'd0);
		read_cell(5'(ROWS - 1), 7'd0);
	endtask

	// Receiver goes quiet while the sender keeps offering: the block backs up.
	task automatic test_backpressure();
		hold_request = 1'b1;
		for (int i = 0; i < 12; i++) begin
			if (i % 3 == 2)
				read_cell(5'($urandom_range(ROWS - 1)), 7'($urandom_range(COLS - 1)));
			else
				put_glyph(random_glyph());
		end
	endtask

	// Sender stops until everything owed has come back, then resumes.
	task automatic test_pause_drain();
		for (int i = 0; i < 10; i++)
			put_glyph(random_glyph());
		wait_drained();
		read_cell(5'(shadow_row), 7'd0);
		peek_cursor();
	endtask

	// Random mix, weighted toward text and reads so the cursor moves down
	// the screen; clears are rare since they walk every cell.
	task automatic test_random_traffic(int count);
		int pick;
		logic [7:0] code;
		logic [4:0] rd_row;
		logic [6:0] rd_col;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			code = 8'($urandom_range(255));
			rd_row = 5'($urandom_range(31));
			rd_col = 7'($urandom_range(127));
			if (pick < 50) begin
				send_item(tmtw_pkg::ACT_PUT, random_glyph(), rd_row, rd_col);
			end else if (pick < 56) begin
				send_item(tmtw_pkg::ACT_PUT, tmtw_pkg::CH_NEWLINE, rd_row, rd_col);
			end else if (pick < 74) begin
				send_item(tmtw_pkg::ACT_READ, code, 5'($urandom_range(ROWS - 1)),
					7'($urandom_range(COLS - 1)));
			end else if (pick < 82) begin
				// near the cursor, where the writes land
				send_item(tmtw_pkg::ACT_READ, code,
					5'((shadow_row < ROWS) ? shadow_row : ROWS - 1),
					7'($urandom_range(shadow_column < COLS ? shadow_column : COLS - 1)));
			end else if (pick < 89) begin
				send_item(tmtw_pkg::ACT_READ, code, rd_row, rd_col);
			end else if (pick < 90) begin
				send_item(tmtw_pkg::ACT_CLEAR, code, rd_row, rd_col);
			end else if (pick < 93) begin
				send_item(tmtw_pkg::action_t'(ACT_UNUSED), code, rd_row, rd_col);
			end else begin
				send_item(tmtw_pkg::ACT_PUT, code, rd_row, rd_col);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Run
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		item_bus.valid = 1'b0;
		item_bus.action = tmtw_pkg::ACT_PUT;
		item_bus.char_code = '0;
		item_bus.read_row = '0;
		item_bus.read_column = '0;
		hold_request = 1'b0;
		mismatch_count = 0;
		quiet_cycles = 0;
		shadow_attr = tmtw_pkg::ATTR_RESET;
		shadow_row = 0;
		shadow_column = 0;
		blank_cells(0, CELLS);

		// Sender idles lightly, receiver heavily.
		sender_idle_pct = 16;
		receiver_idle_pct = 64;

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Reset attribute holds until the first result proves the blanking
		// pass is over; set_attribute drains first.
		test_reset_screen();
		test_put_basics();
		set_attribute(8'hFF);
		test_line_wrap();
		test_backpressure();
		set_attribute(8'h00);
		test_scroll_bottom();
		test_bottom_clamp();

		// Swap: sender idles heavily, receiver lightly.
		sender_idle_pct = 64;
		receiver_idle_pct = 16;
		set_attribute(8'($urandom_range(1, 254)));
		test_random_traffic(190);
		test_pause_drain();
		set_attribute(8'($urandom_range(255)));
		test_backpressure();

		// No idling at all.
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		test_random_traffic(190);
		set_attribute(tmtw_pkg::ATTR_RESET);
		test_line_wrap();
		test_random_traffic(20);

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && screen_reports_due.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire
